>>> src/ujm_pkg.sv
// Shared types, constants and helpers for the UTF-8 to JNI mangled ASCII converter.
package ujm_pkg;

    // Default depth of the job queue between decoder and emitter
    localparam int QueueDepth = 4;

    // Unicode limits used by the strict decoder
    localparam logic [20:0] MaxScalar  = 21'h10FFFF;
    localparam logic [20:0] SurrFirst  = 21'h00D800;
    localparam logic [20:0] SurrLast   = 21'h00DFFF;
    localparam logic [20:0] SupplBase  = 21'h010000;
    localparam logic [20:0] Min2Byte   = 21'h000080;
    localparam logic [20:0] Min3Byte   = 21'h000800;

    // ASCII characters used in the mangled form
    localparam logic [6:0] ChUnder = 7'h5F;
    localparam logic [6:0] ChZero  = 7'h30;
    localparam logic [6:0] ChOne   = 7'h31;
    localparam logic [6:0] ChTwo   = 7'h32;
    localparam logic [6:0] ChThree = 7'h33;
    localparam logic [6:0] ChSlash = 7'h2F;
    localparam logic [6:0] ChSemi  = 7'h3B;
    localparam logic [6:0] ChBrack = 7'h5B;
    localparam logic [6:0] ChNul   = 7'h00;

    // What the emitter has to produce for one queued job
    typedef enum logic [2:0] {
        K_PASS,   // one character
        K_PAIR,   // '_' then one character
        K_ESC1,   // one _0xxxx escape
        K_ESC2,   // two _0xxxx escapes (surrogate pair)
        K_ERR     // one error item
    } t_kind;

    typedef enum logic [2:0] {
        E_OK         = 3'd0,
        E_BAD_LEAD   = 3'd1,
        E_TRUNC      = 3'd2,
        E_BAD_CONT   = 3'd3,
        E_NON_SCALAR = 3'd4
    } t_err;

    // One classified job from the decoder
    typedef struct packed {
        t_kind       kind;
        t_err        err;
        logic        last_in_name;
        logic [15:0] unit0;   // character or first UTF-16 unit
        logic [15:0] unit1;   // second UTF-16 unit
    } t_job;

    // Lower-case hex digit
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (7'h30 + {3'b000, nib}) : (7'h57 + {3'b000, nib});
    endfunction

endpackage

>>> src/ujm_front.sv
// Strict UTF-8 decoder: turns accepted bytes into classified output jobs.
module ujm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_end,
    output logic            o_push,
    output ujm_pkg::t_job   o_job
);
    import ujm_pkg::*;

    // Map a complete scalar to its output job
    function automatic t_job classify(input logic [20:0] cp, input logic last);
        t_job        j;
        logic [19:0] s;
        j              = '0;
        j.err          = E_OK;
        j.last_in_name = last;
        s              = 20'(cp - SupplBase);
        if ((cp >= 21'h61 && cp <= 21'h7A) || (cp >= 21'h41 && cp <= 21'h5A) ||
            (cp >= 21'h30 && cp <= 21'h39)) begin
            j.kind  = K_PASS;
            j.unit0 = {9'd0, cp[6:0]};
        end else if (cp == {14'd0, ChSlash}) begin
            j.kind  = K_PASS;
            j.unit0 = {9'd0, ChUnder};
        end else if (cp == {14'd0, ChUnder}) begin
            j.kind  = K_PAIR;
            j.unit0 = {9'd0, ChOne};
        end else if (cp == {14'd0, ChSemi}) begin
            j.kind  = K_PAIR;
            j.unit0 = {9'd0, ChTwo};
        end else if (cp == {14'd0, ChBrack}) begin
            j.kind  = K_PAIR;
            j.unit0 = {9'd0, ChThree};
        end else if (cp[20:16] == 5'd0) begin
            j.kind  = K_ESC1;
            j.unit0 = cp[15:0];
        end else begin
            j.kind  = K_ESC2;
            j.unit0 = {6'b110110, s[19:10]};
            j.unit1 = {6'b110111, s[9:0]};
        end
        return j;
    endfunction

    logic [20:0] r_acc, n_acc;
    logic [1:0]  r_rem, n_rem;
    logic [1:0]  r_len, n_len;
    logic        r_drop, n_drop;

    logic        lead_ok;
    logic [1:0]  lead_len;
    logic [20:0] lead_acc;
    logic [20:0] cont_acc;
    logic [20:0] min_cp;
    logic        do_err;
    t_err        err_code;

    // Lead byte class
    always_comb begin
        lead_ok  = 1'b1;
        lead_len = 2'd0;
        lead_acc = '0;
        if (i_byte[7:5] == 3'b110) begin
            lead_len = 2'd1;
            lead_acc = {16'd0, i_byte[4:0]};
        end else if (i_byte[7:4] == 4'b1110) begin
            lead_len = 2'd2;
            lead_acc = {17'd0, i_byte[3:0]};
        end else if (i_byte[7:3] == 5'b11110) begin
            lead_len = 2'd3;
            lead_acc = {18'd0, i_byte[2:0]};
        end else begin
            lead_ok = 1'b0;
        end
    end

    assign cont_acc = {r_acc[14:0], i_byte[5:0]};

    // Smallest scalar that the current sequence length may encode
    always_comb begin
        case (r_len)
            2'd1:    min_cp = Min2Byte;
            2'd2:    min_cp = Min3Byte;
            default: min_cp = SupplBase;
        endcase
    end

    // Decoder next state and job
    always_comb begin
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_len    = r_len;
        n_drop   = r_drop;
        o_push   = 1'b0;
        o_job    = '0;
        do_err   = 1'b0;
        err_code = E_OK;
        if (i_accept) begin
            if (r_drop) begin
                if (i_end) begin
                    n_drop = 1'b0;
                end
            end else if (r_rem == 2'd0) begin
                if (!i_byte[7]) begin
                    o_push = 1'b1;
                    o_job  = classify({13'd0, i_byte}, i_end);
                end else if (!lead_ok) begin
                    do_err   = 1'b1;
                    err_code = E_BAD_LEAD;
                end else if (i_end) begin
                    do_err   = 1'b1;
                    err_code = E_TRUNC;
                end else begin
                    n_len = lead_len;
                    n_rem = lead_len;
                    n_acc = lead_acc;
                end
            end else if (i_end && r_rem > 2'd1) begin
                do_err   = 1'b1;
                err_code = E_TRUNC;
            end else if (i_byte[7:6] != 2'b10) begin
                do_err   = 1'b1;
                err_code = E_BAD_CONT;
            end else if (r_rem != 2'd1) begin
                n_acc = cont_acc;
                n_rem = r_rem - 2'd1;
            end else if (cont_acc < min_cp || cont_acc > MaxScalar ||
                         (cont_acc >= SurrFirst && cont_acc <= SurrLast)) begin
                do_err   = 1'b1;
                err_code = E_NON_SCALAR;
            end else begin
                o_push = 1'b1;
                o_job  = classify(cont_acc, i_end);
                n_acc  = '0;
                n_rem  = 2'd0;
                n_len  = 2'd0;
            end

            // Error item clears the decoder and drops the rest of the name
            if (do_err) begin
                o_push             = 1'b1;
                o_job              = '0;
                o_job.kind         = K_ERR;
                o_job.err          = err_code;
                o_job.last_in_name = i_end;
                n_acc              = '0;
                n_rem              = 2'd0;
                n_len              = 2'd0;
                n_drop             = !i_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_rem  <= 2'd0;
            r_len  <= 2'd0;
            r_drop <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_rem  <= n_rem;
            r_len  <= n_len;
            r_drop <= n_drop;
        end
    end

endmodule

>>> src/ujm_queue.sv
// Small register FIFO of decoded jobs between the decoder and the emitter.
module ujm_queue #(
    parameter int DEPTH = ujm_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ujm_pkg::t_job   i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ujm_pkg::t_job   o_job
);
    import ujm_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    // Pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> src/ujm_back.sv
// Emitter: expands each job into mangled characters, one item per cycle while the output is taken.
module ujm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  ujm_pkg::t_job   i_job,
    output logic            o_pop,
    input  logic            i_m_ready,
    output logic            o_m_valid,
    output logic [6:0]      o_char,
    output logic            o_run_last,
    output logic            o_name_end,
    output logic [2:0]      o_err
);
    import ujm_pkg::*;

    logic [3:0]  r_idx, n_idx;
    logic        r_valid;
    logic [6:0]  r_char;
    logic        r_run_last;
    logic        r_name_end;
    logic [2:0]  r_err;

    logic [3:0]  last_idx;
    logic        is_last;
    logic        second;
    logic [2:0]  pos;
    logic [15:0] unit;
    logic [3:0]  nib;
    logic [6:0]  ch;
    logic        load;

    // Index of the final character of this job
    always_comb begin
        case (i_job.kind)
            K_PAIR:  last_idx = 4'd1;
            K_ESC1:  last_idx = 4'd5;
            K_ESC2:  last_idx = 4'd11;
            default: last_idx = 4'd0;
        endcase
    end

    assign is_last = (r_idx == last_idx);
    assign second  = (r_idx >= 4'd6);
    assign pos     = second ? 3'(r_idx - 4'd6) : r_idx[2:0];
    assign unit    = second ? i_job.unit1 : i_job.unit0;

    // Hex nibble for positions two to five of an escape
    always_comb begin
        case (pos)
            3'd2:    nib = unit[15:12];
            3'd3:    nib = unit[11:8];
            3'd4:    nib = unit[7:4];
            default: nib = unit[3:0];
        endcase
    end

    // Character at the current index
    always_comb begin
        case (i_job.kind)
            K_PASS:  ch = i_job.unit0[6:0];
            K_PAIR:  ch = (r_idx == 4'd0) ? ChUnder : i_job.unit0[6:0];
            K_ESC1, K_ESC2: begin
                if (pos == 3'd0) begin
                    ch = ChUnder;
                end else if (pos == 3'd1) begin
                    ch = ChZero;
                end else begin
                    ch = hex_char(nib);
                end
            end
            default: ch = ChNul;
        endcase
    end

    // Load the output register from a queued job whenever it is empty or being taken
    assign load  = i_job_valid && (!r_valid || i_m_ready);
    assign o_pop = load && is_last;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = is_last ? 4'd0 : r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char     <= ch;
            r_run_last <= is_last;
            r_name_end <= is_last && i_job.last_in_name;
            r_err      <= i_job.err;
        end
    end

    assign o_m_valid  = r_valid;
    assign o_char     = r_char;
    assign o_run_last = r_run_last;
    assign o_name_end = r_name_end;
    assign o_err      = r_err;

endmodule

>>> src/utf8_to_jni_mangled_ascii.sv
// The first character of a byte's result is registered in the job queue and then in the output register.
// Throughput: one input byte per cycle while the job queue has room; one output item per cycle while m_tready is high.
// A scalar's result is a plain character, a '_' pair, one _0xxxx escape or two escapes (surrogate pair);
// the output register is the limit, so escaped scalars back up the job queue until it is full.
// Reset (synchronous, active low) clears the decoder, empties the queue and drops m_tvalid.
module utf8_to_jni_mangled_ascii #(
    parameter int QUEUE_DEPTH = ujm_pkg::QueueDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_name
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] run_last
    output logic       m_tlast,   // name_end
    output logic [2:0] m_tuser    // [2:0] error_code
);
    import ujm_pkg::*;

    logic accept;
    logic push;
    logic full;
    logic pop;
    logic job_valid;
    t_job in_job;
    t_job out_job;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    // Decoder front
    ujm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_tdata),
        .i_end    (s_tlast),
        .o_push   (push),
        .o_job    (in_job)
    );

    // Job queue
    ujm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (in_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (out_job)
    );

    // Character emitter
    ujm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (out_job),
        .o_pop       (pop),
        .i_m_ready   (m_tready),
        .o_m_valid   (m_tvalid),
        .o_char      (m_tdata[6:0]),
        .o_run_last  (m_tdata[7]),
        .o_name_end  (m_tlast),
        .o_err       (m_tuser)
    );

endmodule

>>> src/ujm_check.sv
// Port-level checker for the converter, bound to the top level.
module ujm_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [2:0] m_tuser
);

    // A stalled output item holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output item changed while stalled");

    // An error is a single NUL item that closes the byte's run
    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser != 3'd0 |-> m_tdata[6:0] == 7'd0 && m_tdata[7])
        else $error("error item not a lone NUL");

    // End of name only on the final item of a byte
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> m_tdata[7])
        else $error("name end without run end");

    // Error codes stay in range
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tuser <= 3'd4)
        else $error("error code out of range");

    // Nothing is offered right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind utf8_to_jni_mangled_ascii ujm_check u_check (.*);
